FILE: hw/rtl/aes_enc_pkg.sv
// Shared types, constants and byte functions for the AES block encrypt core.
// No dependencies; used by every module under hw/rtl.
package aes_enc_pkg;

    localparam int MAX_ROUNDS = 14;
    localparam int MIN_ROUNDS = 10;
    localparam int KEY_SLOTS  = MAX_ROUNDS + 1;
    localparam int SLOT_W     = $clog2(KEY_SLOTS);
    localparam int BLOCK_W    = 128;

    // tuser bit 0
    localparam logic OP_KEY_WRITE = 1'b0;
    localparam logic OP_ENCRYPT   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDKEY,
        ST_ROUND
    } enc_state_t;

    typedef logic [7:0] byte_t;
    typedef byte_t [15:0] block_bytes_t;

    // round key store write port
    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    addr;
        logic [BLOCK_W-1:0]   data;
    } key_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

FILE: hw/rtl/aes_enc_key_ram.sv
// Round key store: one 128-bit entry per round, registered read.
// Depends on aes_enc_pkg.
module aes_enc_key_ram (
    input  logic                                aclk,
    input  aes_enc_pkg::key_wr_t                wr,
    input  logic [aes_enc_pkg::SLOT_W-1:0]      rd_addr,
    output logic [aes_enc_pkg::BLOCK_W-1:0]     rd_data
);

    logic [aes_enc_pkg::BLOCK_W-1:0] mem [aes_enc_pkg::KEY_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/aes_enc_round.sv
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes_enc_pkg. Byte 0 of the state sits in bits 127:120.
module aes_enc_round (
    input  logic [aes_enc_pkg::BLOCK_W-1:0] state_in,
    input  logic [aes_enc_pkg::BLOCK_W-1:0] round_key,
    input  logic                            final_round,
    output logic [aes_enc_pkg::BLOCK_W-1:0] state_out
);

    aes_enc_pkg::block_bytes_t s;
    aes_enc_pkg::block_bytes_t k;
    aes_enc_pkg::block_bytes_t t;
    aes_enc_pkg::block_bytes_t m;
    aes_enc_pkg::block_bytes_t o;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127-8*i -: 8];
            k[i] = round_key[127-8*i -: 8];
        end
        // sub bytes + shift rows; the state is column-major
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[4*c+r] = aes_enc_pkg::sbox(s[4*((c+r)%4)+r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            m[4*c]   = aes_enc_pkg::xtime(t[4*c]) ^ aes_enc_pkg::xtime(t[4*c+1])
                       ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+1] = t[4*c] ^ aes_enc_pkg::xtime(t[4*c+1])
                       ^ aes_enc_pkg::xtime(t[4*c+2]) ^ t[4*c+2] ^ t[4*c+3];
            m[4*c+2] = t[4*c] ^ t[4*c+1] ^ aes_enc_pkg::xtime(t[4*c+2])
                       ^ aes_enc_pkg::xtime(t[4*c+3]) ^ t[4*c+3];
            m[4*c+3] = aes_enc_pkg::xtime(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                       ^ aes_enc_pkg::xtime(t[4*c+3]);
        end
        for (int i = 0; i < 16; i++) begin
            o[i] = (final_round ? t[i] : m[i]) ^ k[i];
            state_out[127-8*i -: 8] = o[i];
        end
    end

endmodule

FILE: hw/rtl/aes_block_encrypt.sv
// AES forward cipher, one 128-bit block per encrypt word, with the round keys loaded beforehand
// by key-write words (slot r holds round key r, slots above 14 are dropped). A key write is
// taken while idle and leaves the input open. An encrypt word runs the initial AddRoundKey and
// then each round in turn through a single shared round unit, and no new word is taken until
// its last round is done; the round count is round_count clamped to 10..14, and the rate
// is set by that one round unit and the registered read of the key store. The result
// waits in an output register; a new word is taken while it waits, and an encrypt stalls in
// its last round only if the previous result has still not been taken.
// Depends on aes_enc_pkg, aes_enc_key_ram and aes_enc_round.
module aes_block_encrypt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [3:0]     cfg_wdata,      // round_count
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,        // data_high[63:0], data_low[127:64]
    input  logic [4:0]     s_tuser,        // opcode[0], key_slot[4:1]
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata         // cipher_high[63:0], cipher_low[127:64]
);

    localparam int SW = aes_enc_pkg::SLOT_W;

    aes_enc_pkg::enc_state_t state_reg, state_next;
    logic [SW-1:0]  round_reg, round_next;
    logic [SW-1:0]  rounds_reg, rounds_next;
    logic [127:0]   blk_reg, blk_next;
    logic [127:0]   out_data_reg, out_data_next;
    logic           out_valid_reg, out_valid_next;

    logic [SW-1:0]  rd_addr;
    logic [127:0]   key_data;
    logic [127:0]   round_out;
    logic           last_round;
    logic           in_fire;
    aes_enc_pkg::key_wr_t key_wr;

    assign in_fire    = s_tvalid && s_tready;
    assign last_round = (round_reg == rounds_reg);
    assign s_tready   = (state_reg == aes_enc_pkg::ST_IDLE);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

    always_comb begin
        key_wr.en   = in_fire && (s_tuser[0] == aes_enc_pkg::OP_KEY_WRITE)
                      && (s_tuser[4:1] <= 4'(aes_enc_pkg::MAX_ROUNDS));
        key_wr.addr = s_tuser[4:1];
        key_wr.data = {s_tdata[63:0], s_tdata[127:64]};
    end

    always_comb begin
        if (cfg_wdata < 4'(aes_enc_pkg::MIN_ROUNDS)) begin
            rounds_next = SW'(aes_enc_pkg::MIN_ROUNDS);
        end else if (cfg_wdata > 4'(aes_enc_pkg::MAX_ROUNDS)) begin
            rounds_next = SW'(aes_enc_pkg::MAX_ROUNDS);
        end else begin
            rounds_next = cfg_wdata;
        end
    end

    aes_enc_key_ram u_key_ram (
        .aclk    (aclk),
        .wr      (key_wr),
        .rd_addr (rd_addr),
        .rd_data (key_data)
    );

    aes_enc_round u_round (
        .state_in    (blk_reg),
        .round_key   (key_data),
        .final_round (last_round),
        .state_out   (round_out)
    );

    // the key for the next state is addressed in this one, as the key store read is registered
    always_comb begin
        state_next     = state_reg;
        round_next     = round_reg;
        blk_next       = blk_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        rd_addr        = '0;
        unique case (state_reg)
            aes_enc_pkg::ST_IDLE: begin
                rd_addr = '0;
                if (in_fire && (s_tuser[0] == aes_enc_pkg::OP_ENCRYPT)) begin
                    blk_next   = {s_tdata[63:0], s_tdata[127:64]};
                    state_next = aes_enc_pkg::ST_ADDKEY;
                end
            end
            aes_enc_pkg::ST_ADDKEY: begin
                rd_addr    = SW'(1);
                blk_next   = blk_reg ^ key_data;
                round_next = SW'(1);
                state_next = aes_enc_pkg::ST_ROUND;
            end
            aes_enc_pkg::ST_ROUND: begin
                if (!last_round) begin
                    rd_addr    = round_reg + SW'(1);
                    blk_next   = round_out;
                    round_next = round_reg + SW'(1);
                end else begin
                    // hold the key address while the output slot is busy
                    rd_addr = round_reg;
                    if (!out_valid_reg || m_tready) begin
                        out_data_next  = {round_out[63:0], round_out[127:64]};
                        out_valid_next = 1'b1;
                        state_next     = aes_enc_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = aes_enc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aes_enc_pkg::ST_IDLE;
            round_reg     <= '0;
            rounds_reg    <= SW'(aes_enc_pkg::MIN_ROUNDS);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                rounds_reg <= rounds_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg      <= blk_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: hw/rtl/aes_enc_checker.sv
// Port-level checks for aes_block_encrypt, attached by the bind at the end.
// Depends on aes_enc_pkg and aes_block_encrypt.
module aes_enc_checker (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic [4:0]     s_tuser,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [127:0]   m_tdata
);

    // a held result word does not change
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // an encrypt word keeps the input closed through the AddRoundKey state and the first round
    a_enc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == aes_enc_pkg::OP_ENCRYPT)
        |=> !s_tready ##1 !s_tready)
        else $error("input reopened during an encryption");

    // a key write completes in its own cycle
    a_key_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == aes_enc_pkg::OP_KEY_WRITE)
        |=> s_tready)
        else $error("key write stalled the input");

    // a new result appears exactly as the core goes back to idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready && !$past(s_tready))
        else $error("result appeared outside the end of an encryption");

endmodule

bind aes_block_encrypt aes_enc_checker u_aes_enc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
